>>> rtl/llcp_pkg.sv
// Shared constants and types for the line-to-line closest point pipeline.
// No dependencies; llcp_if, llcp_mul and line_line_closest_points_3d use this package.
`default_nettype none

package llcp_pkg;

  // Digit width of the multi-cycle multipliers (one digit pair per stage).
  localparam int MUL_DIGIT = 32;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int EPS_W      = 16;

  // Reset values of the thresholds.
  localparam logic [EPS_W-1:0] COORD_EPS_RST = 16'd1;
  localparam logic [EPS_W-1:0] DENOM_EPS_RST = 16'd1;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COORD_EPS = 8'd0,
    REG_DENOM_EPS = 8'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> rtl/llcp_if.sv
// Channel interfaces of the closest point block: input, result and config.
// Depends on llcp_pkg for the configuration port widths.
`default_nettype none

interface llcp_in_if #(parameter int CW = 32);
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_start_z;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] first_end_z;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_start_z;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;
  logic signed [CW-1:0] second_end_z;

  modport source (
    output valid, first_start_x, first_start_y, first_start_z,
    output first_end_x, first_end_y, first_end_z,
    output second_start_x, second_start_y, second_start_z,
    output second_end_x, second_end_y, second_end_z,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_start_z,
    input  first_end_x, first_end_y, first_end_z,
    input  second_start_x, second_start_y, second_start_z,
    input  second_end_x, second_end_y, second_end_z,
    output ready
  );
endinterface

interface llcp_out_if #(parameter int CW = 32);
  logic          valid;
  logic          ready;
  logic          found;
  logic signed [CW-1:0] near_first_x;
  logic signed [CW-1:0] near_first_y;
  logic signed [CW-1:0] near_first_z;
  logic signed [CW-1:0] near_second_x;
  logic signed [CW-1:0] near_second_y;
  logic signed [CW-1:0] near_second_z;
  logic signed [CW-1:0] param_first;
  logic signed [CW-1:0] param_second;

  modport source (
    output valid, found, near_first_x, near_first_y, near_first_z,
    output near_second_x, near_second_y, near_second_z,
    output param_first, param_second,
    input  ready
  );
  modport sink (
    input  valid, found, near_first_x, near_first_y, near_first_z,
    input  near_second_x, near_second_y, near_second_z,
    input  param_first, param_second,
    output ready
  );
endinterface

interface llcp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [llcp_pkg::CFG_IDX_W-1:0]    index;
  logic [llcp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/llcp_mul.sv
// Pipelined signed multiplier: one MUL_DIGIT by MUL_DIGIT digit pair per stage.
// Depends on llcp_pkg for the digit width.
`default_nettype none

module llcp_mul #(
  parameter int WA = 64,
  parameter int WB = 64
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import llcp_pkg::*;

  localparam int D   = MUL_DIGIT;
  localparam int NA  = (WA + D - 1) / D;
  localparam int NB  = (WB + D - 1) / D;
  localparam int NS  = NA * NB;
  localparam int WXA = NA * D;
  localparam int WXB = NB * D;
  localparam int WC  = WXA + WXB;

  logic signed [WXA-1:0] a_q   [0:NS-2];
  logic signed [WXB-1:0] b_q   [0:NS-2];
  logic signed [WC-1:0]  acc_q [0:NS-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int I = k % NA;
    localparam int J = k / NA;
    logic signed [WXA-1:0] a_in;
    logic signed [WXB-1:0] b_in;
    logic signed [WC-1:0]  acc_in;
    logic signed [D:0]     da;
    logic signed [D:0]     db;
    logic signed [2*D+1:0] pp;
    logic signed [WC-1:0]  term;

    if (k == 0) begin : g_first
      assign a_in   = WXA'(a_i);
      assign b_in   = WXB'(b_i);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[k-1];
      assign b_in   = b_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    // Lower digits are unsigned; the top digit of each operand carries the sign.
    if (I < NA - 1) begin : g_ua
      assign da = $signed({1'b0, a_in[D*I +: D]});
    end else begin : g_sa
      assign da = $signed({a_in[D*I+D-1], a_in[D*I +: D]});
    end

    if (J < NB - 1) begin : g_ub
      assign db = $signed({1'b0, b_in[D*J +: D]});
    end else begin : g_sb
      assign db = $signed({b_in[D*J+D-1], b_in[D*J +: D]});
    end

    assign pp   = da * db;
    assign term = WC'(pp) <<< (D * (I + J));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= acc_in + term;
      end
    end

    if (k < NS - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[k] <= a_in;
          b_q[k] <= b_in;
        end
      end
    end
  end

  assign p_o = acc_q[NS-1][WA+WB-1:0];

endmodule

`default_nettype wire

>>> rtl/llcp_dly.sv
// Enabled delay line that keeps side values aligned with the arithmetic units.
// No dependencies.
`default_nettype none

module llcp_dly #(
  parameter int W = 32,
  parameter int N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] tap_q [0:N-1];

  // Shift one place on every advance.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

`default_nettype wire

>>> rtl/llcp_div.sv
// Pipelined rounding divider: one quotient bit per stage, then round and saturate.
// No package dependency.
`default_nettype none

module llcp_div #(
  parameter int CW = 32,
  parameter int WN = 64,
  parameter int WD = 64
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WN-1:0] n_i,
  input  logic signed [WD-1:0] d_i,
  output logic signed [CW-1:0] q_o
);
  localparam int QB = CW + 1;
  localparam int WC = WN + WD + QB;
  localparam int WQ = CW + 2;

  logic [WN-1:0] r_q   [0:QB];
  logic [WD-1:0] ad_q  [0:QB];
  logic          neg_q [0:QB];
  logic [QB-1:0] q_q   [1:QB];
  logic          ovf_q [1:QB];

  logic [WQ-1:0] qr_q;
  logic          negr_q;
  logic          ovfr_q;
  logic [CW-1:0] res_q;

  // Magnitudes and the sign of the quotient.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= n_i[WN-1] ? WN'(~n_i + 1'b1) : WN'(n_i);
      ad_q[0]  <= d_i[WD-1] ? WD'(~d_i + 1'b1) : WD'(d_i);
      neg_q[0] <= n_i[WN-1] ^ d_i[WD-1];
    end
  end

  // Restoring steps, most significant quotient bit first.
  for (genvar j = 1; j <= QB; j++) begin : g_step
    localparam int SH = QB - j;
    logic [WC-1:0] dsh;
    logic          ge;
    logic [QB-1:0] qin;
    logic          ovfin;

    assign dsh = WC'(ad_q[j-1]) << SH;
    assign ge  = WC'(r_q[j-1]) >= dsh;

    if (j == 1) begin : g_first
      assign qin   = '0;
      assign ovfin = WC'(r_q[0]) >= (WC'(ad_q[0]) << QB);
    end else begin : g_next
      assign qin   = q_q[j-1];
      assign ovfin = ovf_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? WN'(WC'(r_q[j-1]) - dsh) : r_q[j-1];
        q_q[j]   <= qin | (ge ? (QB'(1) << SH) : QB'(0));
        ad_q[j]  <= ad_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovfin;
      end
    end
  end

  // Round half away from zero on the magnitude.
  logic rnd;
  assign rnd = (WC'(r_q[QB]) << 1) >= WC'(ad_q[QB]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qr_q   <= WQ'(q_q[QB]) + WQ'(rnd);
      negr_q <= neg_q[QB];
      ovfr_q <= ovf_q[QB];
    end
  end

  // Saturate to the signed range and apply the sign.
  logic [WQ-1:0] lim;
  logic [WQ-1:0] qs;
  assign lim = negr_q ? (WQ'(1) << (CW - 1)) : ((WQ'(1) << (CW - 1)) - WQ'(1));
  assign qs  = (ovfr_q || (qr_q > lim)) ? lim : qr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= negr_q ? CW'(~qs + 1'b1) : CW'(qs);
    end
  end

  assign q_o = res_q;

endmodule

`default_nettype wire

>>> rtl/line_line_closest_points_3d.sv
// Closest points between two 3D lines in signed fixed point.
// The pipeline depth is set by the digit-pair multiplier banks (9, 15 and 14 stages) and
// the bit-per-stage dividers (36).
// Throughput: one beat per cycle; the pipeline stops only while both entries of the
// two-entry output buffer are full.
// Reset clears the valid bits, empties the output buffer and sets both thresholds to 1.
`default_nettype none

module line_line_closest_points_3d #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  llcp_cfg_if.sink        cfg_i,
  llcp_in_if.sink         in_i,
  llcp_out_if.source      out_o
);
  import llcp_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DFW  = CW + 1;
  localparam int PW   = 2 * DFW;
  localparam int DTW  = PW + 2;
  localparam int NW   = 2 * DTW + 1;
  localparam int BW   = NW + DTW + 1;
  localparam int N2W  = BW + DFW + 1;
  localparam int FW   = NW + EPS_W + 3 * F;
  localparam int MD   = MUL_DIGIT;
  localparam int NDT  = (DTW + MD - 1) / MD;
  localparam int NCH1 = NDT * NDT;
  localparam int NCH2 = ((NW + MD - 1) / MD) * NDT;
  localparam int NCH3 = ((BW + MD - 1) / MD) * ((DFW + MD - 1) / MD);
  localparam int DIVL = CW + 4;
  localparam int L    = 9 + NCH1 + NCH2 + NCH3 + DIVL;
  localparam int RESW = 1 + 8 * CW;

  logic en;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [EPS_W-1:0] coord_eps_q;
  logic [EPS_W-1:0] denom_eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_eps_q <= COORD_EPS_RST;
      denom_eps_q <= DENOM_EPS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_COORD_EPS: coord_eps_q <= cfg_i.data[EPS_W-1:0];
        REG_DENOM_EPS: denom_eps_q <= cfg_i.data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits travel alongside the data.
  logic [L-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the input beat.
  logic signed [CW-1:0] p_q [0:3][0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0][0] <= in_i.first_start_x;
      p_q[0][1] <= in_i.first_start_y;
      p_q[0][2] <= in_i.first_start_z;
      p_q[1][0] <= in_i.first_end_x;
      p_q[1][1] <= in_i.first_end_y;
      p_q[1][2] <= in_i.first_end_z;
      p_q[2][0] <= in_i.second_start_x;
      p_q[2][1] <= in_i.second_start_y;
      p_q[2][2] <= in_i.second_start_z;
      p_q[3][0] <= in_i.second_end_x;
      p_q[3][1] <= in_i.second_end_y;
      p_q[3][2] <= in_i.second_end_z;
    end
  end

  // Stage 2: direction vectors and the offset between the start points.
  logic signed [DFW-1:0] d21_q [0:2];
  logic signed [DFW-1:0] d43_q [0:2];
  logic signed [DFW-1:0] d13_q [0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        d21_q[c] <= DFW'(p_q[1][c]) - DFW'(p_q[0][c]);
        d43_q[c] <= DFW'(p_q[3][c]) - DFW'(p_q[2][c]);
        d13_q[c] <= DFW'(p_q[0][c]) - DFW'(p_q[2][c]);
      end
    end
  end

  // Stage 3: short-direction test and the fifteen component products.
  logic [DFW-1:0]       mag21 [0:2];
  logic [DFW-1:0]       mag43 [0:2];
  logic                 tiny21;
  logic                 tiny43;
  logic                 tiny_q;
  logic signed [PW-1:0] pr_q [0:14];

  always_comb begin
    tiny21 = 1'b1;
    tiny43 = 1'b1;
    for (int c = 0; c < 3; c++) begin
      mag21[c] = d21_q[c][DFW-1] ? DFW'(~d21_q[c] + 1'b1) : DFW'(d21_q[c]);
      mag43[c] = d43_q[c][DFW-1] ? DFW'(~d43_q[c] + 1'b1) : DFW'(d43_q[c]);
      if (mag21[c] >= DFW'(coord_eps_q)) tiny21 = 1'b0;
      if (mag43[c] >= DFW'(coord_eps_q)) tiny43 = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tiny_q <= tiny21 | tiny43;
      for (int c = 0; c < 3; c++) begin
        pr_q[c]      <= d13_q[c] * d43_q[c];
        pr_q[3 + c]  <= d43_q[c] * d21_q[c];
        pr_q[6 + c]  <= d13_q[c] * d21_q[c];
        pr_q[9 + c]  <= d43_q[c] * d43_q[c];
        pr_q[12 + c] <= d21_q[c] * d21_q[c];
      end
    end
  end

  // Stage 4: dot products d1343, d4321, d1321, d4343, d2121.
  logic signed [DTW-1:0] dt_q [0:4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        dt_q[k] <= DTW'(pr_q[3*k]) + DTW'(pr_q[3*k+1]) + DTW'(pr_q[3*k+2]);
      end
    end
  end

  // Multiplier bank 1: determinant and numerator terms.
  logic signed [2*DTW-1:0] m1_t;
  logic signed [2*DTW-1:0] m1_u;
  logic signed [2*DTW-1:0] m1_t2;
  logic signed [2*DTW-1:0] m1_u2;

  llcp_mul #(.WA(DTW), .WB(DTW)) u_mul_t (
    .clk_i, .en_i(en), .a_i(dt_q[4]), .b_i(dt_q[3]), .p_o(m1_t)
  );
  llcp_mul #(.WA(DTW), .WB(DTW)) u_mul_u (
    .clk_i, .en_i(en), .a_i(dt_q[1]), .b_i(dt_q[1]), .p_o(m1_u)
  );
  llcp_mul #(.WA(DTW), .WB(DTW)) u_mul_t2 (
    .clk_i, .en_i(en), .a_i(dt_q[0]), .b_i(dt_q[1]), .p_o(m1_t2)
  );
  llcp_mul #(.WA(DTW), .WB(DTW)) u_mul_u2 (
    .clk_i, .en_i(en), .a_i(dt_q[2]), .b_i(dt_q[3]), .p_o(m1_u2)
  );

  // Side values held until they meet the multiplier results.
  logic          tiny_d;
  logic [DTW-1:0] dot_d [0:2];
  logic signed [DTW-1:0] d1343_a;
  logic signed [DTW-1:0] d4321_a;
  logic signed [DTW-1:0] d4343_a;
  logic [CW-1:0]  p0_d  [0:2];
  logic [CW-1:0]  p2_d  [0:2];
  logic [DFW-1:0] d21_d [0:2];
  logic [DFW-1:0] d43_d [0:2];

  llcp_dly #(.W(1), .N(NCH1 + 2)) u_dly_tiny (
    .clk_i, .en_i(en), .d_i(tiny_q), .q_o(tiny_d)
  );
  llcp_dly #(.W(DTW), .N(NCH1 + 2)) u_dly_d1343 (
    .clk_i, .en_i(en), .d_i(dt_q[0]), .q_o(dot_d[0])
  );
  llcp_dly #(.W(DTW), .N(NCH1 + 2)) u_dly_d4321 (
    .clk_i, .en_i(en), .d_i(dt_q[1]), .q_o(dot_d[1])
  );
  llcp_dly #(.W(DTW), .N(NCH1 + 2)) u_dly_d4343 (
    .clk_i, .en_i(en), .d_i(dt_q[3]), .q_o(dot_d[2])
  );

  assign d1343_a = dot_d[0];
  assign d4321_a = dot_d[1];
  assign d4343_a = dot_d[2];

  for (genvar c = 0; c < 3; c++) begin : g_side
    llcp_dly #(.W(CW), .N(NCH1 + 5)) u_dly_p0 (
      .clk_i, .en_i(en), .d_i(p_q[0][c]), .q_o(p0_d[c])
    );
    llcp_dly #(.W(CW), .N(NCH1 + NCH2 + 6)) u_dly_p2 (
      .clk_i, .en_i(en), .d_i(p_q[2][c]), .q_o(p2_d[c])
    );
    llcp_dly #(.W(DFW), .N(NCH1 + 4)) u_dly_d21 (
      .clk_i, .en_i(en), .d_i(d21_q[c]), .q_o(d21_d[c])
    );
    llcp_dly #(.W(DFW), .N(NCH1 + NCH2 + 5)) u_dly_d43 (
      .clk_i, .en_i(en), .d_i(d43_q[c]), .q_o(d43_d[c])
    );
  end

  // Stage 5: determinant and first numerator.
  logic signed [NW-1:0] den5_q;
  logic signed [NW-1:0] num5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den5_q <= NW'(m1_t) - NW'(m1_u);
      num5_q <= NW'(m1_t2) - NW'(m1_u2);
    end
  end

  // Stage 6: parallel-line test, merged with the short-direction flag.
  logic [NW-1:0]        den_mag;
  logic                 flat;
  logic signed [NW-1:0] den_q;
  logic signed [NW-1:0] num_q;
  logic                 fail6_q;

  assign den_mag = den5_q[NW-1] ? NW'(~den5_q + 1'b1) : NW'(den5_q);
  assign flat    = (den5_q == '0) || (FW'(den_mag) < (FW'(denom_eps_q) << (3 * F)));

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q   <= den5_q;
      num_q   <= num5_q;
      fail6_q <= tiny_d | flat;
    end
  end

  // Multiplier bank 2: terms of the second numerator and of the first points.
  logic signed [NW+DTW-1:0] m2_bigd;
  logic signed [NW+DTW-1:0] m2_tn;
  logic signed [NW+DTW-1:0] m2_un;
  logic signed [NW+DTW-1:0] m2_pd [0:2];
  logic signed [NW+DTW-1:0] m2_nd [0:2];

  llcp_mul #(.WA(NW), .WB(DTW)) u_mul_bigd (
    .clk_i, .en_i(en), .a_i(den_q), .b_i(d4343_a), .p_o(m2_bigd)
  );
  llcp_mul #(.WA(NW), .WB(DTW)) u_mul_tn (
    .clk_i, .en_i(en), .a_i(den_q), .b_i(d1343_a), .p_o(m2_tn)
  );
  llcp_mul #(.WA(NW), .WB(DTW)) u_mul_un (
    .clk_i, .en_i(en), .a_i(num_q), .b_i(d4321_a), .p_o(m2_un)
  );

  for (genvar c = 0; c < 3; c++) begin : g_m2
    logic signed [DTW-1:0] p0_x;
    logic signed [DTW-1:0] d21_x;
    logic signed [CW-1:0]  p0_s;
    logic signed [DFW-1:0] d21_s;

    assign p0_s  = p0_d[c];
    assign d21_s = d21_d[c];
    assign p0_x  = DTW'(p0_s);
    assign d21_x = DTW'(d21_s);

    llcp_mul #(.WA(NW), .WB(DTW)) u_mul_pd (
      .clk_i, .en_i(en), .a_i(den_q), .b_i(p0_x), .p_o(m2_pd[c])
    );
    llcp_mul #(.WA(NW), .WB(DTW)) u_mul_nd (
      .clk_i, .en_i(en), .a_i(num_q), .b_i(d21_x), .p_o(m2_nd[c])
    );
  end

  // Stage 7: scaled second determinant, second numerator, first-point numerators.
  logic signed [BW-1:0] bigd7_q;
  logic signed [BW-1:0] nb7_q;
  logic signed [BW-1:0] n1_q [0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bigd7_q <= BW'(m2_bigd);
      nb7_q   <= BW'(m2_tn) + BW'(m2_un);
      for (int c = 0; c < 3; c++) begin
        n1_q[c] <= BW'(m2_pd[c]) + BW'(m2_nd[c]);
      end
    end
  end

  // Multiplier bank 3: terms of the second-line points.
  logic signed [BW+DFW-1:0] m3_bp [0:2];
  logic signed [BW+DFW-1:0] m3_nq [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_m3
    logic signed [DFW-1:0] p2_x;
    logic signed [DFW-1:0] d43_x;
    logic signed [CW-1:0]  p2_s;

    assign p2_s  = p2_d[c];
    assign p2_x  = DFW'(p2_s);
    assign d43_x = d43_d[c];

    llcp_mul #(.WA(BW), .WB(DFW)) u_mul_bp (
      .clk_i, .en_i(en), .a_i(bigd7_q), .b_i(p2_x), .p_o(m3_bp[c])
    );
    llcp_mul #(.WA(BW), .WB(DFW)) u_mul_nq (
      .clk_i, .en_i(en), .a_i(nb7_q), .b_i(d43_x), .p_o(m3_nq[c])
    );
  end

  // Stage 8: second-point numerators.
  logic signed [N2W-1:0] n2_q [0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        n2_q[c] <= N2W'(m3_bp[c]) + N2W'(m3_nq[c]);
      end
    end
  end

  // Dividend and divisor alignment for the dividers.
  logic [NW-1:0]   den_dd;
  logic [NW+F-1:0] numsh_dd;
  logic [BW-1:0]   bigd_dd;
  logic [BW+F-1:0] nbsh_dd;
  logic [BW-1:0]   n1_dd [0:2];
  logic            fail_d;

  llcp_dly #(.W(NW), .N(NCH2 + NCH3 + 2)) u_dly_den (
    .clk_i, .en_i(en), .d_i(den_q), .q_o(den_dd)
  );
  llcp_dly #(.W(NW + F), .N(NCH2 + NCH3 + 2)) u_dly_num (
    .clk_i, .en_i(en), .d_i({num_q, F'(0)}), .q_o(numsh_dd)
  );
  llcp_dly #(.W(BW), .N(NCH3 + 1)) u_dly_bigd (
    .clk_i, .en_i(en), .d_i(bigd7_q), .q_o(bigd_dd)
  );
  llcp_dly #(.W(BW + F), .N(NCH3 + 1)) u_dly_nb (
    .clk_i, .en_i(en), .d_i({nb7_q, F'(0)}), .q_o(nbsh_dd)
  );
  llcp_dly #(.W(1), .N(NCH2 + NCH3 + 2 + DIVL)) u_dly_fail (
    .clk_i, .en_i(en), .d_i(fail6_q), .q_o(fail_d)
  );

  // Dividers: two parameters and six coordinates.
  logic signed [CW-1:0] q_pf;
  logic signed [CW-1:0] q_ps;
  logic signed [CW-1:0] q_nf [0:2];
  logic signed [CW-1:0] q_ns [0:2];

  llcp_div #(.CW(CW), .WN(NW + F), .WD(NW)) u_div_pf (
    .clk_i, .en_i(en), .n_i(numsh_dd), .d_i(den_dd), .q_o(q_pf)
  );
  llcp_div #(.CW(CW), .WN(BW + F), .WD(BW)) u_div_ps (
    .clk_i, .en_i(en), .n_i(nbsh_dd), .d_i(bigd_dd), .q_o(q_ps)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div
    llcp_dly #(.W(BW), .N(NCH3 + 1)) u_dly_n1 (
      .clk_i, .en_i(en), .d_i(n1_q[c]), .q_o(n1_dd[c])
    );
    llcp_div #(.CW(CW), .WN(BW), .WD(NW)) u_div_nf (
      .clk_i, .en_i(en), .n_i(n1_dd[c]), .d_i(den_dd), .q_o(q_nf[c])
    );
    llcp_div #(.CW(CW), .WN(N2W), .WD(BW)) u_div_ns (
      .clk_i, .en_i(en), .n_i(n2_q[c]), .d_i(bigd_dd), .q_o(q_ns[c])
    );
  end

  // Stage 9: clear everything on a degenerate or parallel pair.
  logic [RESW-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fail_d) begin
        res_q <= '0;
      end else begin
        res_q <= {1'b1, q_nf[0], q_nf[1], q_nf[2], q_ns[0], q_ns[1], q_ns[2], q_pf, q_ps};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer; the pipeline advances whenever it is not full.
  logic [RESW-1:0] buf_q [0:1];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      cnt_q;
  logic [1:0]      cnt_d;
  logic            push;
  logic            pop;
  logic [RESW-1:0] head;

  assign en   = (cnt_q != 2'd2);
  assign push = en && vld_q[L-1];
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_q;
    end
  end

  assign head        = buf_q[rd_ptr_q];
  assign in_i.ready  = en;
  assign out_o.valid = (cnt_q != 2'd0);

  assign out_o.found         = head[RESW-1];
  assign out_o.near_first_x  = head[8*CW-1 -: CW];
  assign out_o.near_first_y  = head[7*CW-1 -: CW];
  assign out_o.near_first_z  = head[6*CW-1 -: CW];
  assign out_o.near_second_x = head[5*CW-1 -: CW];
  assign out_o.near_second_y = head[4*CW-1 -: CW];
  assign out_o.near_second_z = head[3*CW-1 -: CW];
  assign out_o.param_first   = head[2*CW-1 -: CW];
  assign out_o.param_second  = head[CW-1 -: CW];

  // ---------------------------------------------------------------------------
  // Assertions

  // A finished item stays in the last stage while the buffer is full.
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[L-1] && !en) |=> vld_q[L-1])
    else $error("last pipeline item lost during stall");

  // A pop without a push drops the buffer count by one.
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("output buffer count mismatch on pop");

  // A result without a solution carries zeros; checked on both parameters and two coordinates.
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |->
      (out_o.param_first == '0 && out_o.param_second == '0 &&
       out_o.near_first_x == '0 && out_o.near_second_z == '0))
    else $error("non-zero fields on a result without a solution");

endmodule

`default_nettype wire
